// File: sv/fcp_pkg.sv
`timescale 1ns / 1ps

package fcp_pkg;

    // chunk counter width
    localparam int COUNT_BITS = 16;
    localparam int PROD_W     = COUNT_BITS + 15;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [2:0]            t_cmd;
    typedef logic [1:0]            t_phase;
    typedef logic [1:0]            t_cfg_index;

    // event codes
    localparam t_cmd CMD_CHUNK_DONE = 3'd0;
    localparam t_cmd CMD_VSYNC      = 3'd1;
    localparam t_cmd CMD_BUF_RETURN = 3'd2;
    localparam t_cmd CMD_START      = 3'd3;
    localparam t_cmd CMD_STOP       = 3'd4;

    // capture phase codes
    localparam t_phase PH_IDLE  = 2'd0;
    localparam t_phase PH_FILL1 = 2'd1;
    localparam t_phase PH_FILL2 = 2'd2;

    // register indexes
    localparam t_cfg_index REG_VSYNC_FRAMED = 2'd0;
    localparam t_cfg_index REG_CHUNKS       = 2'd1;
    localparam t_cfg_index REG_CHUNK_BYTES  = 2'd2;
    localparam t_cfg_index REG_BUFFER_MASK  = 2'd3;

    typedef struct packed {
        logic        vsync_framed;
        logic [15:0] chunks_per_frame;
        logic [14:0] chunk_bytes;
        logic [1:0]  buffer_mask;
    } t_cfg;

    typedef struct packed {
        logic        copy_valid;
        logic        copy_buffer;
        logic [29:0] copy_offset;
        logic        copy_source_half;
        logic        frame_done;
        logic        done_buffer;
        logic [30:0] frame_length;
        logic        dma_start_pulse;
        logic        dma_stop_pulse;
        logic        vsync_armed;
        logic        dma_running;
    } t_result;

endpackage

// File: sv/frame_capture_pingpong_controller.sv
`timescale 1ns / 1ps

// frame capture ping-pong controller
// input channel: one event per transaction (i_cmd, i_buffer_id) on
//   i_in_valid / o_in_ready; events are chunk done, vsync, buffer
//   returned, start and stop
// output channel: exactly one result transaction per event on
//   o_out_valid / i_out_ready, carrying the copy order, frame-done
//   report, dma start/stop pulses and the vsync/dma flags after the event
// config channel: i_cfg_valid / o_cfg_ready with register index and data,
//   always ready; write only while the block is idle
// pipeline: an accepted event waits in the event register, and its result is
//   computed by the single 16x15 offset multiply between the event register and
//   the result register; throughput is one event per cycle while i_out_ready stays high
// stalls: while the result register is held by i_out_ready low, one more
//   event is still taken into the event register, then o_in_ready drops
// reset: synchronous active low; clears the pipeline, returns to idle with
//   both buffers ready, vsync disarmed, dma stopped and the registers at
//   their defaults

module frame_capture_pingpong_controller
    import fcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event transactions
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic        i_buffer_id,
    // result transactions
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_copy_valid,
    output logic        o_copy_buffer,
    output logic [29:0] o_copy_offset,
    output logic        o_copy_source_half,
    output logic        o_frame_done,
    output logic        o_done_buffer,
    output logic [30:0] o_frame_length,
    output logic        o_dma_start_pulse,
    output logic        o_dma_stop_pulse,
    output logic        o_vsync_armed,
    output logic        o_dma_running,
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // event register
    logic    r_ev_valid;
    logic    n_ev_valid;
    t_cmd    r_ev_cmd;
    logic    r_ev_bid;

    // result register
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;

    logic    out_free;
    logic    ev_fire;
    logic    in_fire;
    t_cfg    cfg;
    t_result step_res;

    assign o_cfg_ready = 1'b1;

    fcp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // the result register frees up when empty or being drained this cycle
    assign out_free   = !r_out_valid || i_out_ready;
    assign ev_fire    = r_ev_valid && out_free;
    assign o_in_ready = !r_ev_valid || out_free;
    assign in_fire    = i_in_valid && o_in_ready;

    // state update and result computed in the same cycle the event moves on
    fcp_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_fire      (ev_fire),
        .i_cmd       (r_ev_cmd),
        .i_buffer_id (r_ev_bid),
        .o_result    (step_res)
    );

    always_comb begin
        n_ev_valid = r_ev_valid;
        if (in_fire) begin
            n_ev_valid = 1'b1;
        end else if (ev_fire) begin
            n_ev_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (ev_fire) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ev_valid  <= n_ev_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ev_cmd <= i_cmd;
            r_ev_bid <= i_buffer_id;
        end
        if (ev_fire) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_copy_valid       = r_out.copy_valid;
    assign o_copy_buffer      = r_out.copy_buffer;
    assign o_copy_offset      = r_out.copy_offset;
    assign o_copy_source_half = r_out.copy_source_half;
    assign o_frame_done       = r_out.frame_done;
    assign o_done_buffer      = r_out.done_buffer;
    assign o_frame_length     = r_out.frame_length;
    assign o_dma_start_pulse  = r_out.dma_start_pulse;
    assign o_dma_stop_pulse   = r_out.dma_stop_pulse;
    assign o_vsync_armed      = r_out.vsync_armed;
    assign o_dma_running      = r_out.dma_running;

endmodule

// File: sv/fcp_cfg.sv
`timescale 1ns / 1ps

module fcp_cfg
    import fcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  t_cfg_index  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_VSYNC_FRAMED: n_cfg.vsync_framed     = i_cfg_data[0];
                REG_CHUNKS:       n_cfg.chunks_per_frame = i_cfg_data;
                REG_CHUNK_BYTES:  n_cfg.chunk_bytes      = i_cfg_data[14:0];
                REG_BUFFER_MASK:  n_cfg.buffer_mask      = i_cfg_data[1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.vsync_framed     <= 1'b0;
            r_cfg.chunks_per_frame <= 16'd1;
            r_cfg.chunk_bytes      <= 15'd1024;
            r_cfg.buffer_mask      <= 2'b11;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/fcp_step.sv
`timescale 1ns / 1ps

module fcp_step
    import fcp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_fire,
    input  t_cmd    i_cmd,
    input  logic    i_buffer_id,
    output t_result o_result
);

    t_phase r_phase;
    t_count r_count;
    logic   r_first_ready;
    logic   r_second_ready;
    logic   r_vsync_en;
    logic   r_dma_on;

    t_phase n_phase;
    t_count n_count;
    logic   n_first_ready;
    logic   n_second_ready;
    logic   n_vsync_en;
    logic   n_dma_on;

    logic              filling;
    logic              cur;
    logic              ready0;
    logic              ready1;
    logic              ready_cur;
    logic              last_chunk;
    logic              ready_after;
    logic [PROD_W-1:0] prod;
    logic [30:0]       length;
    logic [15:0]       count_lo;
    t_result           res;

    assign filling   = (r_phase == PH_FILL1) || (r_phase == PH_FILL2);
    assign cur       = (r_phase == PH_FILL2);
    assign ready0    = r_first_ready & i_cfg.buffer_mask[0];
    assign ready1    = r_second_ready & i_cfg.buffer_mask[1];
    assign ready_cur = cur ? ready1 : ready0;

    // raw frame end test is modulo 2^16, zero register acts as 65536
    assign count_lo   = 16'(32'(r_count));
    assign last_chunk = !i_cfg.vsync_framed
                        && (count_lo == (i_cfg.chunks_per_frame - 16'd1));
    assign ready_after = ready_cur & !last_chunk;

    assign prod   = PROD_W'(r_count) * PROD_W'(i_cfg.chunk_bytes);
    assign length = 31'(prod) + 31'(i_cfg.chunk_bytes);

    always_comb begin
        n_phase        = r_phase;
        n_count        = r_count;
        n_first_ready  = r_first_ready;
        n_second_ready = r_second_ready;
        n_vsync_en     = r_vsync_en;
        n_dma_on       = r_dma_on;
        res            = '0;

        unique case (i_cmd)
            CMD_CHUNK_DONE: begin
                if (r_dma_on && filling) begin
                    if (r_count == '0) begin
                        n_vsync_en = 1'b1;
                    end
                    res.copy_valid       = 1'b1;
                    res.copy_buffer      = cur;
                    res.copy_offset      = 30'(prod);
                    res.copy_source_half = r_count[0];
                    if (i_cfg.vsync_framed && !ready_cur) begin
                        n_dma_on           = 1'b0;
                        res.dma_stop_pulse = 1'b1;
                    end
                    if (last_chunk) begin
                        if (cur) begin
                            n_second_ready = 1'b0;
                        end else begin
                            n_first_ready = 1'b0;
                        end
                    end
                    if (!ready_after) begin
                        res.frame_done   = 1'b1;
                        res.done_buffer  = cur;
                        res.frame_length = length;
                        n_phase          = PH_IDLE;
                    end else if (r_count != COUNT_MAX) begin
                        n_count = r_count + t_count'(1);
                    end
                end
            end
            CMD_VSYNC: begin
                if (r_vsync_en) begin
                    if (!filling) begin
                        // buffer 1 has priority
                        if (ready0 || ready1) begin
                            if (!r_dma_on) begin
                                n_dma_on            = 1'b1;
                                res.dma_start_pulse = 1'b1;
                            end
                            n_vsync_en = 1'b0;
                            n_phase    = ready0 ? PH_FILL1 : PH_FILL2;
                        end
                        n_count = '0;
                    end else if (i_cfg.vsync_framed) begin
                        // frame end marked, next chunk closes it
                        if (cur) begin
                            n_second_ready = 1'b0;
                        end else begin
                            n_first_ready = 1'b0;
                        end
                    end
                end
            end
            CMD_BUF_RETURN: begin
                if (i_buffer_id) begin
                    n_second_ready = 1'b1;
                end else begin
                    n_first_ready = 1'b1;
                end
            end
            CMD_START: begin
                n_vsync_en = 1'b1;
            end
            CMD_STOP: begin
                n_vsync_en = 1'b0;
                if (r_dma_on) begin
                    n_dma_on           = 1'b0;
                    res.dma_stop_pulse = 1'b1;
                end
            end
            default: begin
                res = '0;
            end
        endcase

        res.vsync_armed = n_vsync_en;
        res.dma_running = n_dma_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_count        <= '0;
            r_first_ready  <= 1'b1;
            r_second_ready <= 1'b1;
            r_vsync_en     <= 1'b0;
            r_dma_on       <= 1'b0;
        end else if (i_fire) begin
            r_phase        <= n_phase;
            r_count        <= n_count;
            r_first_ready  <= n_first_ready;
            r_second_ready <= n_second_ready;
            r_vsync_en     <= n_vsync_en;
            r_dma_on       <= n_dma_on;
        end
    end

    assign o_result = res;

endmodule

// File: dv/tb_frame_capture_pingpong_controller.sv
`timescale 1ns / 1ps

module tb_frame_capture_pingpong_controller;
    import fcp_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;

    typedef struct packed {
        t_cmd cmd;
        logic bid;
    } t_event;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [2:0]  i_cmd = '0;
    logic        i_buffer_id = 1'b0;
    logic        i_out_ready = 1'b1;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_copy_valid;
    logic        o_copy_buffer;
    logic [29:0] o_copy_offset;
    logic        o_copy_source_half;
    logic        o_frame_done;
    logic        o_done_buffer;
    logic [30:0] o_frame_length;
    logic        o_dma_start_pulse;
    logic        o_dma_stop_pulse;
    logic        o_vsync_armed;
    logic        o_dma_running;
    logic        o_cfg_ready;

    frame_capture_pingpong_controller dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_cmd              (i_cmd),
        .i_buffer_id        (i_buffer_id),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_copy_valid       (o_copy_valid),
        .o_copy_buffer      (o_copy_buffer),
        .o_copy_offset      (o_copy_offset),
        .o_copy_source_half (o_copy_source_half),
        .o_frame_done       (o_frame_done),
        .o_done_buffer      (o_done_buffer),
        .o_frame_length     (o_frame_length),
        .o_dma_start_pulse  (o_dma_start_pulse),
        .o_dma_stop_pulse   (o_dma_stop_pulse),
        .o_vsync_armed      (o_vsync_armed),
        .o_dma_running      (o_dma_running),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // capture state copy, at its reset values
    t_cfg   shadow_cfg = {1'b0, 16'd1, 15'd1024, 2'd3};
    t_phase cap_phase  = PH_IDLE;
    t_count cap_count  = '0;
    logic   buf1_ready = 1'b1;
    logic   buf2_ready = 1'b1;
    logic   vs_armed   = 1'b0;
    logic   dma_on     = 1'b0;

    t_event  event_backlog[$];
    t_result due_results[$];
    int      mismatch_count = 0;
    int      cycle_count = 0;
    int      stim_count = 0;

    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;

    // a buffer is usable only when returned and present in the mask
    function automatic logic buffer_ready(logic which);
        if (!which) begin
            return buf1_ready && shadow_cfg.buffer_mask[0];
        end
        return buf2_ready && shadow_cfg.buffer_mask[1];
    endfunction

    function automatic t_result next_capture_result(t_cmd cmd, logic bid);
        t_result     r;
        logic        filling;
        logic        cur;
        logic [47:0] offset_full;
        logic [47:0] length_full;
        r = '0;
        filling = (cap_phase == PH_FILL1) || (cap_phase == PH_FILL2);
        cur = (cap_phase == PH_FILL2);
        offset_full = 48'(cap_count) * 48'(shadow_cfg.chunk_bytes);
        length_full = (48'(cap_count) + 48'd1) * 48'(shadow_cfg.chunk_bytes);
        case (cmd)
            CMD_CHUNK_DONE: begin
                if (dma_on && filling) begin
                    if (cap_count == '0) begin
                        vs_armed = 1'b1;
                    end
                    r.copy_valid = 1'b1;
                    r.copy_buffer = cur;
                    r.copy_offset = offset_full[29:0];
                    r.copy_source_half = cap_count[0];
                    if (shadow_cfg.vsync_framed) begin
                        // jpeg frame ends on the chunk after vsync took the buffer
                        if (!buffer_ready(cur)) begin
                            dma_on = 1'b0;
                            r.dma_stop_pulse = 1'b1;
                        end
                    end else if (16'(cap_count) == shadow_cfg.chunks_per_frame - 16'd1) begin
                        if (cur) begin
                            buf2_ready = 1'b0;
                        end else begin
                            buf1_ready = 1'b0;
                        end
                    end
                    if (!buffer_ready(cur)) begin
                        r.frame_done = 1'b1;
                        r.done_buffer = cur;
                        r.frame_length = length_full[30:0];
                        cap_phase = PH_IDLE;
                    end else if (cap_count != COUNT_MAX) begin
                        cap_count = cap_count + t_count'(1);
                    end
                end
            end
            CMD_VSYNC: begin
                if (vs_armed) begin
                    if (!filling) begin
                        if (buffer_ready(1'b0) || buffer_ready(1'b1)) begin
                            if (!dma_on) begin
                                dma_on = 1'b1;
                                r.dma_start_pulse = 1'b1;
                            end
                            vs_armed = 1'b0;
                            cap_phase = buffer_ready(1'b0) ? PH_FILL1 : PH_FILL2;
                        end
                        cap_count = '0;
                    end else if (shadow_cfg.vsync_framed) begin
                        if (cur) begin
                            buf2_ready = 1'b0;
                        end else begin
                            buf1_ready = 1'b0;
                        end
                    end
                end
            end
            CMD_BUF_RETURN: begin
                if (bid) begin
                    buf2_ready = 1'b1;
                end else begin
                    buf1_ready = 1'b1;
                end
            end
            CMD_START: begin
                vs_armed = 1'b1;
            end
            CMD_STOP: begin
                vs_armed = 1'b0;
                if (dma_on) begin
                    dma_on = 1'b0;
                    r.dma_stop_pulse = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.vsync_armed = vs_armed;
        r.dma_running = dma_on;
        return r;
    endfunction

    function automatic string show_result(t_result r);
        return $sformatf({"copy %0b buf %0d off %0d half %0d | done %0b buf %0d len %0d",
                          " | start %0b stop %0b vs %0b dma %0b"},
                         r.copy_valid, r.copy_buffer, r.copy_offset, r.copy_source_half,
                         r.frame_done, r.done_buffer, r.frame_length,
                         r.dma_start_pulse, r.dma_stop_pulse, r.vsync_armed, r.dma_running);
    endfunction

    task automatic log_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // driver: bursts of transactions separated by random gaps
    always @(posedge i_clk) begin : drive_blk
        t_event ev;
        logic   nxt_valid;
        nxt_valid = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                due_results.push_back(next_capture_result(i_cmd, i_buffer_id));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (event_backlog.size() != 0) begin
                    ev = event_backlog.pop_front();
                    i_cmd <= ev.cmd;
                    i_buffer_id <= ev.bid;
                    nxt_valid = 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left = (cycle_count[12:11] == 2'd0 || $urandom_range(0, 3) == 0)
                                   ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
        i_in_valid <= nxt_valid;
    end

    // monitor: compare each result transaction, stall on its own pattern
    always @(posedge i_clk) begin : watch_blk
        t_result got;
        t_result want;
        logic    ready_next;
        ready_next = 1'b1;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = {o_copy_valid, o_copy_buffer, o_copy_offset, o_copy_source_half,
                       o_frame_done, o_done_buffer, o_frame_length, o_dma_start_pulse,
                       o_dma_stop_pulse, o_vsync_armed, o_dma_running};
                if (due_results.size() == 0) begin
                    log_mismatch({"unexpected result: ", show_result(got)});
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) begin
                        log_mismatch({"\n  expected ", show_result(want),
                                      "\n  actual   ", show_result(got)});
                    end
                end
            end
            // quiet windows without stalls, then windows with rising stall rate
            if (stall_left != 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (cycle_count[10:9] != 2'd0
                         && $urandom_range(0, 7) < cycle_count[10:9]) begin
                stall_left = $urandom_range(0, 7);
                ready_next = 1'b0;
            end
        end
        i_out_ready <= ready_next;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("frame_capture_pingpong_controller regression: fail");
            $finish;
        end
    end

    task automatic queue_event(t_cmd cmd, logic bid);
        event_backlog.push_back('{cmd: cmd, bid: bid});
        stim_count++;
    endtask

    task automatic write_reg(t_cfg_index idx, logic [15:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        case (idx)
            REG_VSYNC_FRAMED: shadow_cfg.vsync_framed = value[0];
            REG_CHUNKS:       shadow_cfg.chunks_per_frame = value;
            REG_CHUNK_BYTES:  shadow_cfg.chunk_bytes = value[14:0];
            REG_BUFFER_MASK:  shadow_cfg.buffer_mask = value[1:0];
            default: begin
            end
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    // sender holds off until every result is back, then a short settle
    task automatic wait_drained();
        @(negedge i_clk);
        while (event_backlog.size() != 0 || i_in_valid || due_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // mostly well-formed capture sequences with random content, some noise
    task automatic queue_random(int unsigned target);
        int unsigned goal;
        int unsigned n;
        goal = stim_count + target;
        while (stim_count < goal) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    if ($urandom_range(0, 3) != 0) begin
                        queue_event(CMD_START, $urandom_range(0, 1));
                    end
                    queue_event(CMD_VSYNC, $urandom_range(0, 1));
                    n = $urandom_range(1, 9);
                    repeat (n) begin
                        if ($urandom_range(0, 5) == 0) begin
                            queue_event(CMD_VSYNC, $urandom_range(0, 1));
                        end
                        queue_event(CMD_CHUNK_DONE, $urandom_range(0, 1));
                    end
                    if ($urandom_range(0, 2) != 0) begin
                        queue_event(CMD_BUF_RETURN, $urandom_range(0, 1));
                    end
                end
                6: queue_event(CMD_BUF_RETURN, $urandom_range(0, 1));
                7: queue_event(CMD_STOP, $urandom_range(0, 1));
                8: queue_event(t_cmd'($urandom_range(0, 7)), $urandom_range(0, 1));
                default: queue_event(CMD_START, $urandom_range(0, 1));
            endcase
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default registers: raw frames of one chunk
        queue_event(CMD_CHUNK_DONE, 1'b0);  // dma off, ignored
        queue_event(CMD_VSYNC, 1'b0);       // vsync disarmed, ignored
        queue_event(t_cmd'(5), 1'b1);
        queue_event(t_cmd'(6), 1'b0);
        queue_event(t_cmd'(7), 1'b1);
        queue_event(CMD_START, 1'b0);
        queue_event(CMD_START, 1'b1);
        queue_event(CMD_VSYNC, 1'b0);       // fill buffer 1, dma start
        queue_event(CMD_CHUNK_DONE, 1'b0);  // one-chunk frame done
        queue_event(CMD_VSYNC, 1'b0);       // buffer 2, dma already on
        queue_event(CMD_BUF_RETURN, 1'b1);  // return while being filled
        queue_event(CMD_CHUNK_DONE, 1'b0);
        queue_event(CMD_VSYNC, 1'b0);       // nothing ready, stays idle
        queue_event(CMD_CHUNK_DONE, 1'b1);  // idle, ignored
        queue_event(CMD_START, 1'b0);       // start with dma running
        queue_event(CMD_BUF_RETURN, 1'b0);
        queue_event(CMD_STOP, 1'b0);
        queue_event(CMD_STOP, 1'b1);        // no second stop pulse
        queue_event(CMD_BUF_RETURN, 1'b1);
        wait_drained();

        // jpeg frame on buffer 2 only
        write_reg(REG_VSYNC_FRAMED, 16'd1);
        write_reg(REG_CHUNKS, 16'hFFFF);
        write_reg(REG_CHUNK_BYTES, 16'd16384);
        write_reg(REG_BUFFER_MASK, 16'd2);
        queue_event(CMD_START, 1'b0);
        queue_event(CMD_VSYNC, 1'b0);
        queue_event(CMD_CHUNK_DONE, 1'b0);
        queue_event(CMD_CHUNK_DONE, 1'b0);
        queue_event(CMD_VSYNC, 1'b1);       // ends the jpeg frame
        queue_event(CMD_CHUNK_DONE, 1'b0);  // done plus stop pulse
        queue_event(CMD_CHUNK_DONE, 1'b0);
        wait_drained();

        // no frame buffer present
        write_reg(REG_BUFFER_MASK, 16'd0);
        queue_event(CMD_BUF_RETURN, 1'b0);
        queue_event(CMD_START, 1'b1);
        queue_event(CMD_VSYNC, 1'b0);
        queue_event(CMD_CHUNK_DONE, 1'b1);
        wait_drained();

        // jpeg frame with the widest chunk size
        write_reg(REG_CHUNK_BYTES, 16'h7FFF);
        write_reg(REG_BUFFER_MASK, 16'd3);
        queue_event(CMD_START, 1'b0);
        queue_event(CMD_VSYNC, 1'b0);
        repeat (20) queue_event(CMD_CHUNK_DONE, 1'b0);
        queue_event(CMD_VSYNC, 1'b0);
        queue_event(CMD_CHUNK_DONE, 1'b0);
        wait_drained();

        // raw frame with a zero chunk register keeps filling
        write_reg(REG_VSYNC_FRAMED, 16'd0);
        write_reg(REG_CHUNKS, 16'd0);
        write_reg(REG_CHUNK_BYTES, 16'd16384);
        write_reg(REG_BUFFER_MASK, 16'd1);
        queue_event(CMD_BUF_RETURN, 1'b0);
        queue_event(CMD_START, 1'b0);
        queue_event(CMD_VSYNC, 1'b0);
        repeat (20) queue_event(CMD_CHUNK_DONE, 1'b1);
        wait_drained();

        // random phases, fresh register settings each time
        repeat (6) begin
            write_reg(REG_VSYNC_FRAMED, 16'($urandom_range(0, 1)));
            write_reg(REG_CHUNKS, ($urandom_range(0, 7) == 0)
                                  ? 16'hFFFF : 16'($urandom_range(1, 6)));
            case ($urandom_range(0, 3))
                0: write_reg(REG_CHUNK_BYTES, 16'd1);
                1: write_reg(REG_CHUNK_BYTES, 16'd16384);
                default: write_reg(REG_CHUNK_BYTES, 16'($urandom_range(1, 16384)));
            endcase
            write_reg(REG_BUFFER_MASK, ($urandom_range(0, 5) < 3)
                                       ? 16'($urandom_range(0, 2)) : 16'd3);
            queue_random(229);
            wait_drained();
        end

        if (mismatch_count == 0 && due_results.size() == 0) begin
            $display("frame_capture_pingpong_controller regression: pass");
        end else begin
            $display("frame_capture_pingpong_controller regression: fail");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/fcp_pkg.sv
sv/fcp_cfg.sv
sv/fcp_step.sv
sv/frame_capture_pingpong_controller.sv
dv/tb_frame_capture_pingpong_controller.sv
